// ===== rtl/core/mmcs_pkg.sv =====
// Shared types and constants for the min/max contrast stretch core.
package mmcs_pkg;

  localparam int PIX_W = 16;
  localparam logic [PIX_W-1:0] PIX_MAX = 16'hFFFF;
  localparam int DIV_STEPS = PIX_W;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // one read request passed from the front to the divider
  typedef struct packed {
    logic             valid;
    logic             eoi;
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic             ovf;
  } job_t;

endpackage

// ===== rtl/core/mmcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mmcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mmcs_front.sv =====
// Front end: takes requests, stores pixels, tracks min/max, issues read jobs.
module mmcs_front #(
  parameter int MAX_PIXELS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic [15:0]         pixel,
  input  logic                last,
  input  logic                q_full,
  output logic                push,
  output mmcs_pkg::job_t      push_data
);
  import mmcs_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIXELS);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  logic             state;
  logic [CW-1:0]    pixel_count;
  logic [CW-1:0]    read_index;
  logic [PIX_W-1:0] run_min;
  logic [PIX_W-1:0] run_max;
  logic             complete;
  logic             dropped;
  job_t             pend;

  logic             accept;
  logic [CW-1:0]    cnt_base;
  logic [CW-1:0]    ridx_base;
  logic [PIX_W-1:0] min_base;
  logic [PIX_W-1:0] max_base;
  logic             drop_base;
  logic             room;
  logic             rd_ok;
  logic [PIX_W-1:0] rdata;

  assign busy   = (state != S_IDLE) || q_full;
  assign accept = start && !busy;

  // a load after a finished image begins a new one
  always_comb begin
    cnt_base  = complete ? '0 : pixel_count;
    ridx_base = complete ? '0 : read_index;
    min_base  = complete ? PIX_MAX : run_min;
    max_base  = complete ? '0 : run_max;
    drop_base = complete ? 1'b0 : dropped;
  end

  assign room  = cnt_base < MAX_CNT;
  assign rd_ok = complete && (read_index < pixel_count);

  mmcs_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (accept && (op == OP_LOAD) && room),
    .waddr (cnt_base[AW-1:0]),
    .wdata (pixel),
    .raddr (read_index[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pixel_count <= '0;
      read_index  <= '0;
      run_min     <= PIX_MAX;
      run_max     <= '0;
      complete    <= 1'b0;
      dropped     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_LOAD) begin
              pixel_count <= room ? cnt_base + 1'b1 : cnt_base;
              run_min     <= (room && pixel < min_base) ? pixel : min_base;
              run_max     <= (room && pixel > max_base) ? pixel : max_base;
              dropped     <= drop_base | !room;
              read_index  <= ridx_base;
              complete    <= last;
            end else begin
              state      <= S_FETCH;
              pend.valid <= rd_ok;
              pend.eoi   <= rd_ok && (read_index + 1'b1 == pixel_count);
              pend.pixel <= '0;
              pend.lo    <= run_min;
              pend.hi    <= (run_max == '0) ? PIX_W'(1) : run_max;
              pend.ovf   <= dropped;
              if (rd_ok) begin
                read_index <= read_index + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    push_data       = pend;
    push_data.pixel = rdata;
  end

  assign push = (state == S_FETCH);

endmodule

// ===== rtl/core/mmcs_queue.sv =====
// Two-entry job queue between front end and divider.
module mmcs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mmcs_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output mmcs_pkg::job_t pop_data,
  output logic           empty
);
  import mmcs_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/mmcs_back.sv =====
// Back end: radix-2 divider that scales a pixel into the output range.
module mmcs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mmcs_pkg::job_t job,
  output logic           pop,
  output logic           done,
  output logic           valid_res,
  output logic [15:0]    norm_value,
  output logic           end_of_image,
  output logic [15:0]    min_value,
  output logic [15:0]    max_value,
  output logic           overflow
);
  import mmcs_pkg::*;

  localparam logic B_IDLE = 1'b0;
  localparam logic B_DIV  = 1'b1;

  logic               state;
  logic [STEP_W-1:0]  step;
  logic [PIX_W-1:0]   rem;
  logic [PIX_W-1:0]   num;
  logic [PIX_W-1:0]   dvs;
  logic [PIX_W-1:0]   quo;

  logic               trivial;
  logic [PIX_W-1:0]   diff;
  logic [2*PIX_W-1:0] scaled;
  logic [PIX_W:0]     rem_sh;
  logic               fits;

  assign pop     = (state == B_IDLE) && !q_empty;
  assign trivial = !job.valid || (job.hi <= job.lo) || (job.pixel <= job.lo);
  assign diff    = job.pixel - job.lo;
  // diff * 65535
  assign scaled  = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};

  assign rem_sh  = {rem, num[PIX_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop) begin
            valid_res    <= job.valid;
            end_of_image <= job.eoi;
            min_value    <= job.lo;
            max_value    <= job.hi;
            overflow     <= job.ovf;
            rem          <= scaled[2*PIX_W-1:PIX_W];
            num          <= scaled[PIX_W-1:0];
            dvs          <= job.hi - job.lo;
            step         <= '0;
            if (trivial) begin
              norm_value <= '0;
              done       <= 1'b1;
            end else begin
              state <= B_DIV;
            end
          end
        end
        default: begin
          rem  <= fits ? PIX_W'(rem_sh - {1'b0, dvs}) : rem_sh[PIX_W-1:0];
          num  <= {num[PIX_W-2:0], 1'b0};
          quo  <= {quo[PIX_W-2:0], fits};
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            norm_value <= {quo[PIX_W-2:0], fits};
            done       <= 1'b1;
            state      <= B_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/minmax_contrast_stretch_core.sv =====
// Top level of the min/max contrast stretch core.
//
//  channel   | handshake                 | signals
//  ----------+---------------------------+------------------------------------------
//  request   | start high, busy low      | op, pixel, last
//  result    | done high for one cycle   | valid_res, norm_value, end_of_image,
//            |                           | min_value, max_value, overflow
//
//  A load gives no result.
//  A read passes a store fetch and the job queue, then the divider forms the 16-bit
//  quotient (one quotient bit per cycle); done is raised after the last divider step.
//  Reads that find no pixel, a zero range or a pixel at the minimum skip the divider
//  steps. The divider takes no new read until the current one is done.
//  Until the two-entry queue fills, the front keeps taking loads while the divider works.
//  rst is synchronous; the pixel store is not cleared. done cannot be stalled.
module minmax_contrast_stretch_core #(
  parameter int MAX_PIXELS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [15:0] pixel,
  input  logic        last,
  output logic        done,
  output logic        valid_res,
  output logic [15:0] norm_value,
  output logic        end_of_image,
  output logic [15:0] min_value,
  output logic [15:0] max_value,
  output logic        overflow
);
  import mmcs_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_data;
  job_t pop_data;

  mmcs_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .pixel     (pixel),
    .last      (last),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  mmcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  mmcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .job          (pop_data),
    .pop          (pop),
    .done         (done),
    .valid_res    (valid_res),
    .norm_value   (norm_value),
    .end_of_image (end_of_image),
    .min_value    (min_value),
    .max_value    (max_value),
    .overflow     (overflow)
  );

endmodule

// ===== rtl/core/mmcs_checker.sv =====
// Port-level checks for the min/max contrast stretch core.
module mmcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        op,
  input logic        done,
  input logic        valid_res,
  input logic [15:0] norm_value,
  input logic        end_of_image,
  input logic [15:0] min_value,
  input logic [15:0] max_value
);
  import mmcs_pkg::*;

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && !valid_res |-> (norm_value == '0) && !end_of_image)
    else $error("result without pixel carries data");

  a_range_order: assert property (@(posedge clk) disable iff (rst)
    done && valid_res |-> max_value >= min_value)
    else $error("valid result with max below min");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("done right after reset");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (op == OP_READ) |=> busy)
    else $error("read request not followed by fetch cycle");

endmodule

bind minmax_contrast_stretch_core mmcs_checker u_mmcs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .done         (done),
  .valid_res    (valid_res),
  .norm_value   (norm_value),
  .end_of_image (end_of_image),
  .min_value    (min_value),
  .max_value    (max_value)
);
